// ===== rtl/core/bounded_deque_positional_edit_macros.svh =====
// Assertion helpers shared by the deque RTL.
// Each expects i_clk and i_rst_n in the scope of use.
`ifndef BOUNDED_DEQUE_POSITIONAL_EDIT_MACROS_SVH
`define BOUNDED_DEQUE_POSITIONAL_EDIT_MACROS_SVH

`define BDPE_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("deque check failed");

`define BDPE_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

`define BDPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// ===== rtl/core/bdpe_pkg.sv =====
package bdpe_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned CNT_W   = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_REVERSE    = 3'd6,
        OP_CLEAR      = 3'd7
    } t_opcode;

    // read address select for the single memory read port
    typedef enum logic [2:0] {
        RD_NONE,
        RD_PREV,
        RD_NEXT,
        RD_CELL,
        RD_FRONT,
        RD_BACK
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_PUT
    } t_wr_sel;

    typedef struct packed {
        logic    latch;
        logic    exec;
        t_rd_sel rd;
        t_wr_sel wr;
        logic    ptr_dec;
        logic    ptr_inc;
        logic    take_cap;
        logic    front_cap;
        logic    count_inc;
        logic    count_dec;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic refuse;
        logic is_put;
        logic is_take;
        logic up_done;
        logic dn_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/bdpe_if.sv =====
interface bdpe_in_if;
    import bdpe_pkg::*;

    logic                      valid;
    logic                      ready;
    t_opcode                   opcode;
    logic signed [FIELD_W-1:0] item_value;
    logic        [POS_W-1:0]   position;

    modport source (output valid, opcode, item_value, position, input ready);
    modport sink   (input valid, opcode, item_value, position, output ready);
endinterface

interface bdpe_out_if;
    import bdpe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] taken_value;
    logic signed [FIELD_W-1:0] front_value;
    logic signed [FIELD_W-1:0] back_value;
    logic        [CNT_W-1:0]   entry_count;
    logic                      status;

    modport source (output valid, taken_value, front_value, back_value, entry_count, status,
                    input ready);
    modport sink   (input valid, taken_value, front_value, back_value, entry_count, status,
                    output ready);
endinterface

// ===== rtl/core/bdpe_ctrl.sv =====
module bdpe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bdpe_pkg::t_sts i_sts,
    output bdpe_pkg::t_cmd o_cmd
);
    import bdpe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_TK_RD,
        S_TK_CAP,
        S_DN_RD,
        S_DN_WR,
        S_RD_F,
        S_RD_B,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.refuse) begin
                    n_state = S_RD_F;
                end else if (i_sts.is_put) begin
                    n_state = S_UP_RD;
                end else if (i_sts.is_take) begin
                    n_state = S_TK_RD;
                end else begin
                    n_state = S_RD_F;
                end
            end
            // open a gap: move words up one cell, top first
            S_UP_RD: begin
                if (i_sts.up_done) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.rd = RD_PREV;
                    n_state  = S_UP_WR;
                end
            end
            S_UP_WR: begin
                o_cmd.wr      = WR_SHIFT;
                o_cmd.ptr_dec = 1'b1;
                n_state       = S_UP_RD;
            end
            S_PUT: begin
                o_cmd.wr        = WR_PUT;
                o_cmd.count_inc = 1'b1;
                n_state         = S_RD_F;
            end
            S_TK_RD: begin
                o_cmd.rd = RD_CELL;
                n_state  = S_TK_CAP;
            end
            S_TK_CAP: begin
                o_cmd.take_cap = 1'b1;
                n_state        = S_DN_RD;
            end
            // close the gap: move words down one cell, bottom first
            S_DN_RD: begin
                if (i_sts.dn_done) begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_RD_F;
                end else begin
                    o_cmd.rd = RD_NEXT;
                    n_state  = S_DN_WR;
                end
            end
            S_DN_WR: begin
                o_cmd.wr      = WR_SHIFT;
                o_cmd.ptr_inc = 1'b1;
                n_state       = S_DN_RD;
            end
            S_RD_F: begin
                o_cmd.rd = RD_FRONT;
                n_state  = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.front_cap = 1'b1;
                o_cmd.rd        = RD_BACK;
                n_state         = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/bdpe_datapath.sv =====
`include "bounded_deque_positional_edit_macros.svh"

module bdpe_datapath #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bdpe_pkg::t_cmd                       i_cmd,
    output bdpe_pkg::t_sts                       o_sts,
    input  bdpe_pkg::t_opcode                    i_opcode,
    input  logic signed [bdpe_pkg::FIELD_W-1:0]  i_item_value,
    input  logic        [bdpe_pkg::POS_W-1:0]    i_position,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [bdpe_pkg::FIELD_W-1:0]  o_taken_value,
    output logic signed [bdpe_pkg::FIELD_W-1:0]  o_front_value,
    output logic signed [bdpe_pkg::FIELD_W-1:0]  o_back_value,
    output logic        [bdpe_pkg::CNT_W-1:0]    o_entry_count,
    output logic                                 o_status
);
    import bdpe_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    t_opcode               r_op;
    logic [DATA_WIDTH-1:0] r_val;
    logic [POS_W-1:0]      r_pos;
    logic [CW-1:0]         r_count;
    logic                  r_rev;
    logic [CW-1:0]         r_cell;
    logic [CW-1:0]         r_ptr;
    logic                  r_status;
    logic [FIELD_W-1:0]    r_taken;
    logic [FIELD_W-1:0]    r_front;

    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_out_taken;
    logic [FIELD_W-1:0]    r_out_front;
    logic [FIELD_W-1:0]    r_out_back;
    logic [CNT_W-1:0]      r_out_count;
    logic                  r_out_status;

    logic [DATA_WIDTH-1:0] in_val;
    logic [FIELD_W-1:0]    rd_wide;
    logic                  full;
    logic                  empty;
    logic                  refuse;
    logic                  is_put;
    logic                  is_take;
    logic [CW-1:0]         last;
    logic [CW-1:0]         lp;
    logic [CW-1:0]         exec_cell;
    logic [CW-1:0]         rd_cell;
    logic [CW-1:0]         wr_cell;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  out_free;

    // stored word width against the 32-bit fields
    generate
        if (DATA_WIDTH <= FIELD_W) begin : g_narrow
            assign in_val = i_item_value[DATA_WIDTH-1:0];
        end else begin : g_wide_in
            assign in_val = {{(DATA_WIDTH - FIELD_W){i_item_value[FIELD_W-1]}}, i_item_value};
        end
        if (DATA_WIDTH >= FIELD_W) begin : g_trunc
            assign rd_wide = r_rdata[FIELD_W-1:0];
        end else begin : g_sext
            assign rd_wide = {{(FIELD_W - DATA_WIDTH){r_rdata[DATA_WIDTH-1]}}, r_rdata};
        end
    endgenerate

    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);
    assign last  = r_count - CW'(1);

    always_comb begin
        refuse  = 1'b0;
        is_put  = 1'b0;
        is_take = 1'b0;
        lp      = '0;
        case (r_op)
            OP_PUSH_FRONT: begin
                refuse = full;
                is_put = 1'b1;
            end
            OP_PUSH_BACK: begin
                refuse = full;
                is_put = 1'b1;
                lp     = r_count;
            end
            OP_POP_FRONT: begin
                refuse  = empty;
                is_take = 1'b1;
            end
            OP_POP_BACK: begin
                refuse  = empty;
                is_take = 1'b1;
                lp      = last;
            end
            OP_INSERT: begin
                refuse = full || (PW'(r_pos) > PW'(r_count));
                is_put = 1'b1;
                lp     = CW'(r_pos);
            end
            OP_REMOVE: begin
                refuse  = (PW'(r_pos) >= PW'(r_count));
                is_take = 1'b1;
                lp      = CW'(r_pos);
            end
            default: begin
                refuse = 1'b0;
            end
        endcase
    end

    // logical place to physical cell; reversed order counts from the top
    always_comb begin
        if (is_put) begin
            exec_cell = r_rev ? (r_count - lp) : lp;
        end else begin
            exec_cell = r_rev ? (last - lp) : lp;
        end
    end

    always_comb begin
        case (i_cmd.rd)
            RD_PREV:  rd_cell = r_ptr - CW'(1);
            RD_NEXT:  rd_cell = r_ptr + CW'(1);
            RD_CELL:  rd_cell = r_cell;
            RD_FRONT: rd_cell = r_rev ? last : '0;
            RD_BACK:  rd_cell = r_rev ? '0 : last;
            default:  rd_cell = '0;
        endcase
    end

    assign wr_cell  = (i_cmd.wr == WR_PUT) ? r_cell : r_ptr;
    assign wr_data  = (i_cmd.wr == WR_PUT) ? r_val : r_rdata;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr != WR_NONE) begin
            r_mem[wr_cell[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd != RD_NONE) begin
            r_rdata <= r_mem[rd_cell[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec && (r_op == OP_REVERSE)) begin
                r_rev <= ~r_rev;
            end
            if (i_cmd.exec && (r_op == OP_CLEAR)) begin
                r_count <= '0;
                r_rev   <= 1'b0;
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.count_dec) begin
                r_count <= last;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_opcode;
            r_val <= in_val;
            r_pos <= i_position;
        end
        if (i_cmd.exec) begin
            r_cell   <= exec_cell;
            r_ptr    <= is_put ? r_count : exec_cell;
            r_status <= refuse;
            r_taken  <= '0;
        end
        if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - CW'(1);
        end
        if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + CW'(1);
        end
        // a remove takes its word silently, only pops report it
        if (i_cmd.take_cap && ((r_op == OP_POP_FRONT) || (r_op == OP_POP_BACK))) begin
            r_taken <= rd_wide;
        end
        if (i_cmd.front_cap) begin
            r_front <= empty ? '0 : rd_wide;
        end
        if (i_cmd.out_load) begin
            r_out_taken  <= r_taken;
            r_out_front  <= r_front;
            r_out_back   <= empty ? '0 : rd_wide;
            r_out_count  <= CNT_W'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_sts.refuse   = refuse;
    assign o_sts.is_put   = is_put;
    assign o_sts.is_take  = is_take;
    assign o_sts.up_done  = (r_ptr == r_cell);
    assign o_sts.dn_done  = ((r_ptr + CW'(1)) >= r_count);
    assign o_sts.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_taken_value = r_out_taken;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

    `BDPE_ASSERT_HOLDS(a_count_bound, r_count <= CW'(CAPACITY))
    `BDPE_ASSERT_IMPLIES(a_no_overfill, i_cmd.count_inc, !full)
    `BDPE_ASSERT_IMPLIES(a_no_underflow, i_cmd.count_dec, !empty)
    `BDPE_ASSERT_IMPLIES(a_load_when_free, i_cmd.out_load, out_free)
    `BDPE_ASSERT_NEXT(a_empty_reads_zero, i_cmd.out_load && empty, r_out_front == '0 && r_out_back == '0)

endmodule

// ===== rtl/core/bounded_deque_positional_edit.sv =====
// Each accepted item is executed first; pushes and inserts move words up to open a gap and
// write the new word, pops and removes read the word and move words down to close the gap;
// reverse, clear and refused items skip this. Each moved word costs one read and one write
// on the cell memory; front and back are then read one after the other. Next item is
// accepted once the result is loaded into the output register, which holds it until taken.
// Reset (synchronous): count and direction cleared, cell contents left undefined.
module bounded_deque_positional_edit #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input logic          i_clk,
    input logic          i_rst_n,
    bdpe_in_if.sink      i_in,
    bdpe_out_if.source   o_out
);
    import bdpe_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    bdpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bdpe_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_in.opcode),
        .i_item_value  (i_in.item_value),
        .i_position    (i_in.position),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (out_valid),
        .o_taken_value (o_out.taken_value),
        .o_front_value (o_out.front_value),
        .o_back_value  (o_out.back_value),
        .o_entry_count (o_out.entry_count),
        .o_status      (o_out.status)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
